FILE: sv/crpc_pkg.sv
`default_nettype none

package crpc_pkg;

    localparam int TABLE_ENTRIES = 256;
    localparam int BYTE_W        = 8;
    localparam int KEY_WORDS     = 4;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 64;

    localparam logic [BYTE_W-1:0] STREAM_MUL = 8'd131;
    localparam logic [BYTE_W-1:0] BYTE_MASK  = 8'hFF;

    typedef logic [BYTE_W-1:0]    t_byte;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    // register indexes on the configuration channel
    localparam t_cfg_idx REG_KEY_WORD_0     = 3'd0;
    localparam t_cfg_idx REG_KEY_WORD_1     = 3'd1;
    localparam t_cfg_idx REG_KEY_WORD_2     = 3'd2;
    localparam t_cfg_idx REG_KEY_WORD_3     = 3'd3;
    localparam t_cfg_idx REG_KEYSTREAM_EN   = 3'd4;
    localparam t_cfg_idx REG_IV_SEED        = 3'd5;
    localparam t_cfg_idx REG_DECRYPT_MODE   = 3'd6;

    // control from the sequencer into the swap address generator
    typedef struct packed {
        logic  start;
        logic  adv;
        t_byte key;
    } t_gen_ctl;

    // current swap pair and whether it closes the reshape
    typedef struct packed {
        t_byte p;
        t_byte q;
        logic  last;
    } t_swap_addr;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_RD    = 6'b000010,
        S_WR    = 6'b000100,
        S_DRAIN = 6'b001000,
        S_LOOK  = 6'b010000,
        S_RESP  = 6'b100000
    } t_state;

endpackage

`default_nettype wire

FILE: sv/crpc_ifs.sv
`default_nettype none

interface crpc_in_if;
    logic                 valid;
    logic                 ready;
    crpc_pkg::t_byte      data_byte;
    logic                 message_start;

    modport source (output valid, output data_byte, output message_start, input ready);
    modport sink   (input valid, input data_byte, input message_start, output ready);
endinterface

interface crpc_out_if;
    logic                 valid;
    logic                 ready;
    crpc_pkg::t_byte      result_byte;

    modport source (output valid, output result_byte, input ready);
    modport sink   (input valid, input result_byte, output ready);
endinterface

interface crpc_cfg_if;
    logic                              valid;
    logic                              ready;
    crpc_pkg::t_cfg_idx                index;
    logic [crpc_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: sv/crpc_table.sv
`default_nettype none

// 256 x 8 table, one write port, two registered read ports.
// An entry without its valid bit reads as its own address (identity).
module crpc_table (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_clr,
    input  wire logic            i_we,
    input  wire crpc_pkg::t_byte i_wa,
    input  wire crpc_pkg::t_byte i_wd,
    input  wire crpc_pkg::t_byte i_ra,
    input  wire crpc_pkg::t_byte i_rb,
    output crpc_pkg::t_byte      o_qa,
    output crpc_pkg::t_byte      o_qb
);

    crpc_pkg::t_byte                      r_mem [crpc_pkg::TABLE_ENTRIES];
    logic [crpc_pkg::TABLE_ENTRIES-1:0]   r_vld;
    crpc_pkg::t_byte                      r_qa;
    crpc_pkg::t_byte                      r_qb;
    crpc_pkg::t_byte                      r_aa;
    crpc_pkg::t_byte                      r_ab;
    logic                                 r_va;
    logic                                 r_vb;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wa] <= i_wd;
        end
        r_qa <= r_mem[i_ra];
        r_qb <= r_mem[i_rb];
        r_aa <= i_ra;
        r_ab <= i_rb;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_vld <= '0;
            r_va  <= 1'b0;
            r_vb  <= 1'b0;
        end else begin
            if (i_we) begin
                r_vld[i_wa] <= 1'b1;
            end
            r_va <= r_vld[i_ra];
            r_vb <= r_vld[i_rb];
        end
    end

    assign o_qa = r_va ? r_qa : r_aa;
    assign o_qb = r_vb ? r_qb : r_ab;

endmodule

// 256 x 8 table, one write port, one registered read port.
// An entry without its valid bit reads as its own address (identity).
module crpc_inv_table (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_clr,
    input  wire logic            i_we,
    input  wire crpc_pkg::t_byte i_wa,
    input  wire crpc_pkg::t_byte i_wd,
    input  wire crpc_pkg::t_byte i_ra,
    output crpc_pkg::t_byte      o_q
);

    crpc_pkg::t_byte                      r_mem [crpc_pkg::TABLE_ENTRIES];
    logic [crpc_pkg::TABLE_ENTRIES-1:0]   r_vld;
    crpc_pkg::t_byte                      r_q;
    crpc_pkg::t_byte                      r_a;
    logic                                 r_v;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wa] <= i_wd;
        end
        r_q <= r_mem[i_ra];
        r_a <= i_ra;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_vld <= '0;
            r_v   <= 1'b0;
        end else begin
            if (i_we) begin
                r_vld[i_wa] <= 1'b1;
            end
            r_v <= r_vld[i_ra];
        end
    end

    assign o_q = r_v ? r_q : r_a;

endmodule

`default_nettype wire

FILE: sv/crpc_swap_gen.sv
`default_nettype none

// Walks the swap pairs of one reshape: whole chunks from entry 0, then the tail.
module crpc_swap_gen (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire crpc_pkg::t_gen_ctl  i_ctl,
    output crpc_pkg::t_swap_addr     o_swap
);

    crpc_pkg::t_byte r_pos;
    crpc_pkg::t_byte r_len;
    logic [6:0]      r_i;

    logic [6:0]      half;
    logic            chunk_end;
    logic [8:0]      np;
    logic [9:0]      np_end;
    logic            fits;
    logic [8:0]      rest;
    logic            tail;
    crpc_pkg::t_byte q_sum;

    assign half      = r_len[7:1];
    assign chunk_end = (r_i + 7'd1) == half;
    assign np        = {1'b0, r_pos} + {1'b0, r_len};
    assign np_end    = {1'b0, np} + {2'b00, r_len};
    assign fits      = np_end <= 10'(crpc_pkg::TABLE_ENTRIES);
    assign rest      = 9'(crpc_pkg::TABLE_ENTRIES) - np;
    assign tail      = rest > 9'd1;
    assign q_sum     = r_pos + r_len - 8'd1 - {1'b0, r_i};

    assign o_swap.p    = r_pos + {1'b0, r_i};
    assign o_swap.q    = q_sum;
    assign o_swap.last = chunk_end && !fits && !tail;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_len <= 8'd2;
            r_i   <= '0;
        end else if (i_ctl.start) begin
            r_pos <= '0;
            r_i   <= '0;
            r_len <= (i_ctl.key < 8'd2) ? 8'd2 : i_ctl.key;
        end else if (i_ctl.adv) begin
            if (!chunk_end) begin
                r_i <= r_i + 7'd1;
            end else begin
                // next chunk, or the shorter tail
                r_i   <= '0;
                r_pos <= np[7:0];
                r_len <= fits ? r_len : rest[7:0];
            end
        end
    end

endmodule

`default_nettype wire

FILE: sv/chunk_reversal_permutation_cipher.sv
`default_nettype none

// Channel  Dir  Payload                         Transaction
// i_in     in   data_byte[8], message_start[1]  valid & ready
// o_out    out  result_byte[8]                  valid & ready
// i_cfg    in   index[3], data[64]              valid & ready (always ready)
//
// Each byte runs one reshape of N swaps (N at most 128): each swap is a read of
// both forward entries and two writes on the single write port of each table;
// drain, lookup and response follow. Reset and message start clear the tables
// to identity through per-entry valid bits. A result waits in the output
// register; a further result holds the sequencer until it is taken. Input is
// taken only between bytes.
module chunk_reversal_permutation_cipher #(
    parameter int KEY_LEN = 32
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    crpc_in_if.sink       i_in,
    crpc_out_if.source    o_out,
    crpc_cfg_if.sink      i_cfg
);

    localparam int KIW = (KEY_LEN > 1) ? $clog2(KEY_LEN) : 1;

    // configuration
    crpc_pkg::t_byte r_key [KEY_LEN];
    logic            r_ks_en;
    crpc_pkg::t_byte r_iv;
    logic            r_dec;

    // sequencer and keystream state
    crpc_pkg::t_state r_state;
    crpc_pkg::t_state n_state;
    logic [KIW-1:0]   r_ki;
    crpc_pkg::t_byte  r_s;
    crpc_pkg::t_byte  r_cnt;
    crpc_pkg::t_byte  r_k;
    crpc_pkg::t_byte  r_data;
    logic             r_w2;
    crpc_pkg::t_byte  r_p;
    crpc_pkg::t_byte  r_q;
    crpc_pkg::t_byte  r_x;
    crpc_pkg::t_byte  r_y;
    logic             r_ov;
    crpc_pkg::t_byte  r_res;

    logic cfg_acc;
    logic in_acc;
    logic out_take;
    logic load_out;

    logic [KIW-1:0]  cur_ki;
    logic [KIW-1:0]  nxt_ki;
    crpc_pkg::t_byte cur_k;
    crpc_pkg::t_byte look_addr;
    crpc_pkg::t_byte res;
    crpc_pkg::t_byte s_prod;
    crpc_pkg::t_byte n_s;

    crpc_pkg::t_gen_ctl   gen_ctl;
    crpc_pkg::t_swap_addr swap;

    logic            fwd_we;
    crpc_pkg::t_byte fwd_wa;
    crpc_pkg::t_byte fwd_wd;
    crpc_pkg::t_byte fwd_ra;
    crpc_pkg::t_byte fwd_qa;
    crpc_pkg::t_byte fwd_qb;
    logic            inv_we;
    crpc_pkg::t_byte inv_wa;
    crpc_pkg::t_byte inv_wd;
    crpc_pkg::t_byte inv_qa;
    logic            stage2;

    assign i_cfg.ready = 1'b1;
    assign cfg_acc     = i_cfg.valid && i_cfg.ready;
    assign i_in.ready  = (r_state == crpc_pkg::S_IDLE);
    assign in_acc      = i_in.valid && i_in.ready;
    assign out_take    = r_ov && o_out.ready;
    assign load_out    = (r_state == crpc_pkg::S_RESP) && (!r_ov || o_out.ready);

    // key bytes: only the ones in use are stored
    for (genvar b = 0; b < KEY_LEN; b++) begin : g_key
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_key[b] <= '0;
            end else if (cfg_acc && i_cfg.index == crpc_pkg::t_cfg_idx'(b / 8)) begin
                r_key[b] <= i_cfg.data[8*(b%8) +: 8];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ks_en <= 1'b0;
            r_iv    <= '0;
            r_dec   <= 1'b0;
        end else if (cfg_acc) begin
            case (i_cfg.index)
                crpc_pkg::REG_KEYSTREAM_EN: r_ks_en <= i_cfg.data[0];
                crpc_pkg::REG_IV_SEED:      r_iv    <= i_cfg.data[7:0];
                crpc_pkg::REG_DECRYPT_MODE: r_dec   <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    assign cur_ki = i_in.message_start ? '0 : r_ki;
    assign cur_k  = r_key[cur_ki];
    assign nxt_ki = (r_ki == KIW'(KEY_LEN - 1)) ? '0 : r_ki + KIW'(1);

    assign gen_ctl.start = in_acc;
    assign gen_ctl.adv   = (r_state == crpc_pkg::S_WR);
    assign gen_ctl.key   = cur_k;

    crpc_swap_gen u_gen (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (gen_ctl),
        .o_swap  (swap)
    );

    assign look_addr = (r_dec && r_ks_en) ? (r_data ^ r_s) : r_data;

    // second half of a swap lands while the next pair is read, or in the drain state after the last swap
    assign stage2 = ((r_state == crpc_pkg::S_RD) && r_w2) || (r_state == crpc_pkg::S_DRAIN);

    always_comb begin
        fwd_ra = (r_state == crpc_pkg::S_RD) ? swap.p : look_addr;
        fwd_we = 1'b0;
        fwd_wa = r_p;
        fwd_wd = fwd_qb;
        inv_we = 1'b0;
        inv_wa = fwd_qa;
        inv_wd = r_q;
        if (r_state == crpc_pkg::S_WR) begin
            fwd_we = 1'b1;
            inv_we = 1'b1;
        end else if (stage2) begin
            fwd_we = 1'b1;
            fwd_wa = r_q;
            fwd_wd = r_x;
            inv_we = 1'b1;
            inv_wa = r_y;
            inv_wd = r_p;
        end
    end

    crpc_table u_fwd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clr   (in_acc && i_in.message_start),
        .i_we    (fwd_we),
        .i_wa    (fwd_wa),
        .i_wd    (fwd_wd),
        .i_ra    (fwd_ra),
        .i_rb    (swap.q),
        .o_qa    (fwd_qa),
        .o_qb    (fwd_qb)
    );

    crpc_inv_table u_inv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clr   (in_acc && i_in.message_start),
        .i_we    (inv_we),
        .i_wa    (inv_wa),
        .i_wd    (inv_wd),
        .i_ra    (look_addr),
        .o_q     (inv_qa)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            crpc_pkg::S_IDLE:  if (in_acc) n_state = crpc_pkg::S_RD;
            crpc_pkg::S_RD:    n_state = crpc_pkg::S_WR;
            crpc_pkg::S_WR:    n_state = swap.last ? crpc_pkg::S_DRAIN : crpc_pkg::S_RD;
            crpc_pkg::S_DRAIN: n_state = crpc_pkg::S_LOOK;
            crpc_pkg::S_LOOK:  n_state = crpc_pkg::S_RESP;
            crpc_pkg::S_RESP:  if (load_out) n_state = crpc_pkg::S_IDLE;
            default:           n_state = crpc_pkg::S_IDLE;
        endcase
    end

    assign res    = r_dec ? inv_qa : (r_ks_en ? (fwd_qa ^ r_s) : fwd_qa);
    assign s_prod = r_s * crpc_pkg::STREAM_MUL;
    assign n_s    = (s_prod + r_k + r_cnt) & crpc_pkg::BYTE_MASK;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= crpc_pkg::S_IDLE;
            r_ki    <= '0;
            r_s     <= '0;
            r_cnt   <= '0;
            r_w2    <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_acc) begin
                r_ki <= cur_ki;
                r_w2 <= 1'b0;
                if (i_in.message_start) begin
                    r_s   <= r_key[0] ^ r_iv;
                    r_cnt <= '0;
                end
            end
            if (r_state == crpc_pkg::S_WR) begin
                r_w2 <= 1'b1;
            end
            if (load_out) begin
                r_ki <= nxt_ki;
                if (r_ks_en) begin
                    r_s   <= n_s;
                    r_cnt <= r_cnt + 8'd1;
                end
            end
            if (load_out) begin
                r_ov <= 1'b1;
            end else if (out_take) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_data <= i_in.data_byte;
            r_k    <= cur_k;
        end
        if (r_state == crpc_pkg::S_RD) begin
            r_p <= swap.p;
            r_q <= swap.q;
        end
        if (r_state == crpc_pkg::S_WR) begin
            r_x <= fwd_qa;
            r_y <= fwd_qb;
        end
        if (load_out) begin
            r_res <= res;
        end
    end

    assign o_out.valid       = r_ov;
    assign o_out.result_byte = r_res;

endmodule

`default_nettype wire
